/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset disable.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, using the usual clock and reset names.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* rtl/bjh_pkg.sv */
// ----------------------------------------------------------------------------
// bjh_pkg
// Shared types and codes for the jump history block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bjh_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int FILE_W   = 16;
  localparam int LINE_W   = 24;
  localparam int COL_W    = 16;
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 8;

  localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BACK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FWD    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_RECORDED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MOVED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_START    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_END      = 3'd5;

  typedef struct packed {
    logic [FILE_W-1:0] file_id;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  column;
    logic [LINE_W-1:0] scroll_line;
    logic [COL_W-1:0]  scroll_col;
    logic              preview;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/bounded_jump_history.sv */
// ----------------------------------------------------------------------------
// bounded_jump_history
// Back/forward location history with a cursor, held as a ring of DEPTH entries.
// ----------------------------------------------------------------------------
// An item is a record, step-back or step-forward command. The ring pointers,
// cursor and count update at the edge that accepts the item, and the entry
// store (one write or one read port, registered read) is accessed at that same
// edge. The result register loads from stage 1 (status and read data) at the
// edge that moves stage 1 out; a stall on the result side can hold it back.
// The two stages overlap: with the result side not stalling, one item is taken
// every cycle. Recording a location whose file id is 0, or an unused command,
// changes nothing and answers "ignored". Entry fields of a result are zero
// unless the status is "moved"; position and entry_count wrap to their port
// widths.
`timescale 1ns / 1ps
`default_nettype none

module bounded_jump_history #(
  parameter int DEPTH = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bjh_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [bjh_pkg::FILE_W-1:0]    file_id_i,
  input  wire logic [bjh_pkg::LINE_W-1:0]    line_i,
  input  wire logic [bjh_pkg::COL_W-1:0]     column_i,
  input  wire logic [bjh_pkg::LINE_W-1:0]    scroll_line_i,
  input  wire logic [bjh_pkg::COL_W-1:0]     scroll_col_i,
  input  wire logic                          preview_flag_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [bjh_pkg::STATUS_W-1:0]       status_o,
  output logic [bjh_pkg::FILE_W-1:0]         out_file_id_o,
  output logic [bjh_pkg::LINE_W-1:0]         out_line_o,
  output logic [bjh_pkg::COL_W-1:0]          out_column_o,
  output logic [bjh_pkg::LINE_W-1:0]         out_scroll_line_o,
  output logic [bjh_pkg::COL_W-1:0]          out_scroll_col_o,
  output logic                               out_preview_o,
  output logic [bjh_pkg::POS_W-1:0]          position_o,
  output logic [bjh_pkg::COUNT_W-1:0]        entry_count_o
);
  import bjh_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // ring slot of history index idx
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [AW-1:0] idx);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, idx};
    if (sum >= DEPTH_S) sum = sum - DEPTH_S;
    return sum[AW-1:0];
  endfunction

  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] held_q, held_d;
  logic [AW-1:0] cursor_q, cursor_d;

  logic                s1_valid_q, s1_valid_d;
  logic [STATUS_W-1:0] s1_status_q, s1_status_d;
  logic                out_valid_q;

  entry_t        mem [DEPTH];
  entry_t        rd_q;
  entry_t        wr_entry;
  logic [AW-1:0] wr_slot, rd_slot, rd_idx, base_slot;
  logic          mem_we, mem_re;

  logic          accept, s1_adv;
  logic [CW-1:0] cur_p1, keep, new_count;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;

  assign wr_entry = '{file_id: file_id_i, line: line_i, column: column_i,
                      scroll_line: scroll_line_i, scroll_col: scroll_col_i,
                      preview: preview_flag_i};

  always_comb begin
    cur_p1 = CW'(cursor_q) + CW'(1);
    // drop entries ahead of the cursor
    keep = (held_q != '0 && cur_p1 < held_q) ? cur_p1 : held_q;
    base_slot = slot_of(oldest_q, keep[AW-1:0]);
    rd_idx    = (cmd_i == CMD_BACK) ? (cursor_q - AW'(1)) : cur_p1[AW-1:0];
    rd_slot   = slot_of(oldest_q, rd_idx);

    oldest_d    = oldest_q;
    held_d      = held_q;
    cursor_d    = cursor_q;
    s1_status_d = s1_status_q;
    wr_slot     = oldest_q;
    new_count   = keep;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    if (accept) begin
      unique case (cmd_i)
        CMD_RECORD: begin
          if (file_id_i == '0) begin
            s1_status_d = ST_IGNORED;
          end else begin
            if (keep < DEPTH_C) begin
              wr_slot   = base_slot;
              new_count = keep + CW'(1);
            end else begin
              // full ring: overwrite the oldest
              wr_slot   = oldest_q;
              new_count = DEPTH_C;
              oldest_d  = slot_of(oldest_q, AW'(1));
            end
            held_d      = new_count;
            cursor_d    = AW'(new_count - CW'(1));
            mem_we      = 1'b1;
            s1_status_d = ST_RECORDED;
          end
        end
        CMD_BACK: begin
          if (held_q == '0) begin
            s1_status_d = ST_EMPTY;
          end else if (cursor_q == '0) begin
            s1_status_d = ST_START;
          end else begin
            cursor_d    = rd_idx;
            mem_re      = 1'b1;
            s1_status_d = ST_MOVED;
          end
        end
        CMD_FWD: begin
          if (held_q == '0) begin
            s1_status_d = ST_EMPTY;
          end else if (cur_p1 >= held_q) begin
            s1_status_d = ST_END;
          end else begin
            cursor_d    = rd_idx;
            mem_re      = 1'b1;
            s1_status_d = ST_MOVED;
          end
        end
        default: begin
          s1_status_d = ST_IGNORED;
        end
      endcase
    end

    s1_valid_d = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_slot] <= wr_entry;
    if (mem_re) rd_q <= mem[rd_slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q    <= '0;
      held_q      <= '0;
      cursor_q    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      oldest_q   <= oldest_d;
      held_q     <= held_d;
      cursor_q   <= cursor_d;
      s1_valid_q <= s1_valid_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_status_q <= s1_status_d;
  end

  // State registers already hold the values after the item in stage 1:
  // a new item is only taken at the edge that moves stage 1 out.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      status_o      <= s1_status_q;
      position_o    <= POS_W'(cursor_q);
      entry_count_o <= COUNT_W'(held_q);
      if (s1_status_q == ST_MOVED) begin
        out_file_id_o     <= rd_q.file_id;
        out_line_o        <= rd_q.line;
        out_column_o      <= rd_q.column;
        out_scroll_line_o <= rd_q.scroll_line;
        out_scroll_col_o  <= rd_q.scroll_col;
        out_preview_o     <= rd_q.preview;
      end else begin
        out_file_id_o     <= '0;
        out_line_o        <= '0;
        out_column_o      <= '0;
        out_scroll_line_o <= '0;
        out_scroll_col_o  <= '0;
        out_preview_o     <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/bjh_checker.sv */
// ----------------------------------------------------------------------------
// bjh_checker
// Port-level checks for the jump history block, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bjh_checker #(
  parameter int DEPTH = 128
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [bjh_pkg::STATUS_W-1:0]  status_o,
  input wire logic [bjh_pkg::FILE_W-1:0]    out_file_id_o,
  input wire logic [bjh_pkg::LINE_W-1:0]    out_line_o,
  input wire logic [bjh_pkg::COL_W-1:0]     out_column_o,
  input wire logic                          out_preview_o,
  input wire logic [bjh_pkg::POS_W-1:0]     position_o,
  input wire logic [bjh_pkg::COUNT_W-1:0]   entry_count_o
);
  import bjh_pkg::*;

  logic big_ring;
  assign big_ring = (DEPTH > 128);

  // stalled result must hold
  `ASSERT_STD(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(position_o) && $stable(out_file_id_o), "result changed while stalled")

  // entry fields only carry data on a move
  `ASSERT_STD(a_zero_fields, out_valid_o && status_o != ST_MOVED |-> out_file_id_o == '0 && out_line_o == '0 && out_column_o == '0 && !out_preview_o, "entry fields set without a move")

  // after a record the cursor sits on the newest entry
  `ASSERT_STD(a_rec_cursor, out_valid_o && status_o == ST_RECORDED |-> position_o == POS_W'(entry_count_o - COUNT_W'(1)), "cursor not on newest after record")

  // cursor stays inside the history
  `ASSERT_STD(a_cursor_range, out_valid_o && entry_count_o != '0 |-> big_ring || COUNT_W'(position_o) < entry_count_o, "cursor beyond history")

endmodule

bind bounded_jump_history bjh_checker #(.DEPTH(DEPTH)) u_bjh_checker (.*);

`default_nettype wire
